[rtl/huftb_pkg.sv]
package huftb_pkg;

    // fixed field widths of the stream payloads
    localparam int IN_WEIGHT_W = 16;
    localparam int IDX_W       = 6;
    localparam int SUM_OUT_W   = 21;
    localparam int OUT_DATA_W  = 3 * IDX_W + SUM_OUT_W + 1;

    // defaults for the top level parameters
    localparam int DEF_MAX_LEAVES  = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    // control of the running two-minimum unit
    typedef struct packed {
        logic             clear;
        logic             sample;
        logic [IDX_W-1:0] idx;
    } min2_ctl_t;

endpackage

[rtl/huftb_node_ram.sv]
module huftb_node_ram
    import huftb_pkg::*;
#(
    parameter int DEPTH  = 2 * DEF_MAX_LEAVES,
    parameter int ADDR_W = $clog2(2 * DEF_MAX_LEAVES),
    parameter int DATA_W = DEF_WEIGHT_BITS + $clog2(DEF_MAX_LEAVES)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/huftb_min2.sv]
module huftb_min2
    import huftb_pkg::*;
#(
    parameter int SUM_W = DEF_WEIGHT_BITS + $clog2(DEF_MAX_LEAVES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  min2_ctl_t        ctl,
    input  logic [SUM_W-1:0] sample_weight,
    output logic [IDX_W-1:0] first_idx,
    output logic [IDX_W-1:0] second_idx,
    output logic [SUM_W-1:0] first_weight,
    output logic [SUM_W-1:0] second_weight
);

    logic             have1_reg, have1_next;
    logic             have2_reg, have2_next;
    logic [IDX_W-1:0] idx1_reg, idx1_next;
    logic [IDX_W-1:0] idx2_reg, idx2_next;
    logic [SUM_W-1:0] w1_reg, w1_next;
    logic [SUM_W-1:0] w2_reg, w2_next;
    logic             below1;
    logic             below2;

    // strict compares keep ties on the lower index seen first
    assign below1 = !have1_reg || (sample_weight < w1_reg);
    assign below2 = !have2_reg || (sample_weight < w2_reg);

    always_comb
    begin
        have1_next = have1_reg;
        have2_next = have2_reg;
        idx1_next  = idx1_reg;
        idx2_next  = idx2_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        if (ctl.clear)
        begin
            have1_next = 1'b0;
            have2_next = 1'b0;
        end
        else if (ctl.sample)
        begin
            if (below1)
            begin
                have2_next = have1_reg;
                idx2_next  = idx1_reg;
                w2_next    = w1_reg;
                have1_next = 1'b1;
                idx1_next  = ctl.idx;
                w1_next    = sample_weight;
            end
            else if (below2)
            begin
                have2_next = 1'b1;
                idx2_next  = ctl.idx;
                w2_next    = sample_weight;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have1_reg <= 1'b0;
            have2_reg <= 1'b0;
        end
        else
        begin
            have1_reg <= have1_next;
            have2_reg <= have2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= idx1_next;
        idx2_reg <= idx2_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
    end

    assign first_idx     = idx1_reg;
    assign second_idx    = idx2_reg;
    assign first_weight  = w1_reg;
    assign second_weight = w2_reg;

endmodule

[rtl/huffman_tree_builder.sv]
// leaf load: one leaf request per cycle, ready held high while loading
// build: internal node k reads nodes 1 .. k-1 through one read port, the reads pass
//   the read and compare pipeline, then a summing state merges them, held by output stall
// a set of n leaves closes with internal node 2n-1, the root
// reset: asynchronous active low, clears leaf count, drop flag, parent bits, state, read and output valid
module huffman_tree_builder
    import huftb_pkg::*;
#(
    parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave side: leaf requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_WEIGHT_W-1:0] s_tdata,  // [15:0] leaf_weight
    input  logic                   s_tlast,  // is_last
    // master side: internal node results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [5:0] node_index, [11:6] left_child, [17:12] right_child,
    // [38:18] node_weight_sum, [39] overflow
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast   // last_node
);

    // node slots 1 .. 2*MAX_LEAVES-1, slot zero unused
    localparam int SLOTS  = 2 * MAX_LEAVES;
    localparam int NODE_W = $clog2(SLOTS);
    localparam int LC_W   = $clog2(MAX_LEAVES + 1);
    localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_LEAVES);
    localparam logic [IN_WEIGHT_W-1:0] IN_MASK = (WEIGHT_BITS >= IN_WEIGHT_W) ?
        {IN_WEIGHT_W{1'b1}} : IN_WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    // sequencer states
    localparam logic [1:0] S_LOAD = 2'd0;  // taking leaves
    localparam logic [1:0] S_SCAN = 2'd1;  // sweeping the store for two minima
    localparam logic [1:0] S_SUM  = 2'd2;  // merge and hand off the result

    logic [1:0]        state_reg, state_next;
    logic [LC_W-1:0]   leaf_count_reg, leaf_count_next;
    logic              dropped_reg, dropped_next;
    logic [SLOTS-1:0]  has_parent_reg, has_parent_next;
    logic [LC_W-1:0]   n_reg, n_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [NODE_W-1:0] scan_idx_reg, scan_idx_next;

    // read pipeline stage in front of the compare unit
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_free_reg, rd_free_next;
    logic [NODE_W-1:0] rd_idx_reg, rd_idx_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    logic                 in_fire;
    logic                 keep_leaf;
    logic [LC_W-1:0]      count_after;
    logic                 out_free;
    logic                 issue;
    logic [NODE_W-1:0]    total;
    logic [SUM_W-1:0]     leaf_value;
    logic [SUM_W-1:0]     node_sum;

    logic                 ram_wr_en;
    logic [NODE_W-1:0]    ram_wr_addr;
    logic [SUM_W-1:0]     ram_wr_data;
    logic [SUM_W-1:0]     ram_rd_data;

    min2_ctl_t            min2_ctl;
    logic [IDX_W-1:0]     min_idx1;
    logic [IDX_W-1:0]     min_idx2;
    logic [SUM_W-1:0]     min_w1;
    logic [SUM_W-1:0]     min_w2;

    assign s_tready    = (state_reg == S_LOAD);
    assign in_fire     = s_tvalid && s_tready;
    assign keep_leaf   = (leaf_count_reg < LC_W'(MAX_LEAVES));
    assign count_after = keep_leaf ? leaf_count_reg + LC_W'(1) : leaf_count_reg;
    assign out_free    = !m_valid_reg || m_tready;
    // only the low weight bits take part
    assign leaf_value  = SUM_W'(s_tdata & IN_MASK);
    // 2n-1 taken in NODE_W bits, exact for any kept n
    assign total       = NODE_W'({n_reg, 1'b0}) - NODE_W'(1);
    // sums never exceed SUM_W bits
    assign node_sum    = min_w1 + min_w2;
    // read every node below the new one
    assign issue       = (state_reg == S_SCAN) && (scan_idx_reg < node_reg);

    always_comb
    begin
        state_next      = state_reg;
        leaf_count_next = leaf_count_reg;
        dropped_next    = dropped_reg;
        has_parent_next = has_parent_reg;
        n_next          = n_reg;
        node_next       = node_reg;
        scan_idx_next   = scan_idx_reg;
        rd_valid_next   = issue;
        rd_idx_next     = scan_idx_reg;
        rd_free_next    = !has_parent_reg[scan_idx_reg];
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = NODE_W'(leaf_count_reg) + NODE_W'(1);
        ram_wr_data     = leaf_value;
        min2_ctl.clear  = 1'b0;
        min2_ctl.sample = rd_valid_reg && rd_free_reg;
        min2_ctl.idx    = IDX_W'(rd_idx_reg);

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    leaf_count_next = count_after;
                    if (keep_leaf)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    else
                    begin
                        // leaf past capacity is dropped
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        if (count_after >= LC_W'(2))
                        begin
                            n_next         = count_after;
                            node_next      = NODE_W'(count_after) + NODE_W'(1);
                            scan_idx_next  = NODE_W'(1);
                            min2_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            // one leaf or none: set ends with no result
                            leaf_count_next = '0;
                            dropped_next    = 1'b0;
                            has_parent_next = '0;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + NODE_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    // last sample has reached the compare unit
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = (node_reg == total);
                    m_data_next  = {dropped_reg,
                                    SUM_OUT_W'(node_sum),
                                    min_idx2,
                                    min_idx1,
                                    IDX_W'(node_reg)};
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = node_reg;
                    ram_wr_data  = node_sum;
                    has_parent_next[min_idx1[NODE_W-1:0]] = 1'b1;
                    has_parent_next[min_idx2[NODE_W-1:0]] = 1'b1;
                    if (node_reg == total)
                    begin
                        // root done, ready for a new set
                        leaf_count_next = '0;
                        dropped_next    = 1'b0;
                        has_parent_next = '0;
                        state_next      = S_LOAD;
                    end
                    else
                    begin
                        node_next      = node_reg + NODE_W'(1);
                        scan_idx_next  = NODE_W'(1);
                        min2_ctl.clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            leaf_count_reg <= '0;
            dropped_reg    <= 1'b0;
            has_parent_reg <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_count_reg <= leaf_count_next;
            dropped_reg    <= dropped_next;
            has_parent_reg <= has_parent_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        node_reg     <= node_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        rd_free_reg  <= rd_free_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    // weight store, one write and one registered read per cycle
    huftb_node_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (NODE_W),
        .DATA_W (SUM_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    // shared compare unit tracking the two lightest parentless nodes
    huftb_min2 #(
        .SUM_W (SUM_W)
    ) u_min2 (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (min2_ctl),
        .sample_weight (ram_rd_data),
        .first_idx     (min_idx1),
        .second_idx    (min_idx2),
        .first_weight  (min_w1),
        .second_weight (min_w2)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
